>>> hw/rtl/bpc_pkg.sv
// Shared types, constants and helpers for the pressure compensation block.
package bpc_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;
  localparam int DivSteps = 32;

  localparam logic [CfgIdxW-1:0] RegTemp  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressA = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressB = 2'd2;
  localparam logic [CfgIdxW-1:0] RegP9 = 2'd3;

  localparam logic [31:0] FineOffset = 32'd64000;
  localparam logic [31:0] FullScale = 32'd1048576;
  localparam logic [31:0] PressScale = 32'd3125;
  localparam logic [31:0] DivBias = 32'd32768;

  // Item handed from the front part to the divider and correction back part.
  typedef struct packed {
    logic        invalid;
    logic        zero_div;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        post_double;
  } bpc_job_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

>>> hw/rtl/bpc_front.sv
// Front part: fine temperature, divisor and dividend, seven register stages.
module bpc_front import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic        bus_error,
  input  logic        advance,
  input  logic [47:0] temp_coeffs,
  input  logic [63:0] press_coeffs_a,
  input  logic [63:0] press_coeffs_b,
  output logic        job_valid,
  output bpc_job_t    job
);

  logic [6:0]  vld;
  logic [5:0]  err;
  logic [19:0] adc_p [0:5];

  // stage 0
  logic [31:0] s0_x, s0_d;
  // stage 1
  logic [31:0] s1_a, s1_dd;
  // stage 2
  logic [31:0] s2_a, s2_b;
  // stage 3
  logic [31:0] s3_a, s3_sq;
  // stage 4
  logic [31:0] s4_sq11, s4_ap5, s4_p3t, s4_p2a;
  // stage 5 regs
  logic [31:0] s5_b, s5_a;
  // stage 6
  logic [31:0] s6_pp, s6_div;
  logic        s6_err;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  logic [31:0] adc_t;
  logic [31:0] c3_tf, c3_a, c5_b, c5_a, c6_b, c6_p;

  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = sx16(temp_coeffs[31:16]);
  assign t3 = sx16(temp_coeffs[47:32]);
  assign p1 = {16'd0, press_coeffs_a[15:0]};
  assign p2 = sx16(press_coeffs_a[31:16]);
  assign p3 = sx16(press_coeffs_a[47:32]);
  assign p4 = sx16(press_coeffs_a[63:48]);
  assign p5 = sx16(press_coeffs_b[15:0]);
  assign p6 = sx16(press_coeffs_b[31:16]);
  assign adc_t = {12'd0, raw_temperature};

  assign c3_tf = s2_a + s2_b;
  assign c3_a = asr(c3_tf, 5'd1) - FineOffset;
  assign c5_b = asr(s4_sq11 + (s4_ap5 << 1), 5'd2) + (p4 << 16);
  assign c5_a = asr(asr(s4_p3t, 5'd3) + asr(s4_p2a, 5'd1), 5'd18);
  assign c6_b = DivBias + s5_a;
  assign c6_p = FullScale - {12'd0, adc_p[5]} - asr(s5_b, 5'd12);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      err <= {err[4:0], bus_error};
      adc_p[0] <= raw_pressure;
      for (int i = 1; i < 6; i++) adc_p[i] <= adc_p[i-1];
      s0_x <= (adc_t >> 3) - (t1 << 1);
      s0_d <= (adc_t >> 4) - t1;
      s1_a <= s0_x * t2;
      s1_dd <= s0_d * s0_d;
      s2_a <= asr(s1_a, 5'd11);
      s2_b <= asr(asr(s1_dd, 5'd12) * t3, 5'd14);
      s3_a <= c3_a;
      s3_sq <= asr(c3_a, 5'd2) * asr(c3_a, 5'd2);
      s4_sq11 <= asr(s3_sq, 5'd11) * p6;
      s4_ap5 <= s3_a * p5;
      s4_p3t <= p3 * asr(s3_sq, 5'd13);
      s4_p2a <= p2 * s3_a;
      s5_b <= c5_b;
      s5_a <= c5_a;
      s6_div <= asr(c6_b * p1, 5'd15);
      s6_pp <= c6_p * PressScale;
      s6_err <= err[5];
    end
  end

  assign job_valid = vld[6];
  always_comb begin
    job.invalid = s6_err;
    job.zero_div = !s6_err && (s6_div == 32'd0);
    job.divisor = s6_div;
    job.post_double = s6_pp[31];
    job.dividend = s6_pp[31] ? s6_pp : (s6_pp << 1);
  end

endmodule

>>> hw/rtl/bpc_queue.sv
// Short queue between the front and back parts.
module bpc_queue import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  input  bpc_job_t wr_data,
  output logic     wr_space,
  output logic     rd_valid,
  input  logic     rd_ready,
  output bpc_job_t rd_data
);

  bpc_job_t mem [0:QueueDepth-1];
  logic [QueuePtrW-1:0] wp, rp;
  logic [QueuePtrW:0] cnt;
  logic do_wr, do_rd;

  assign rd_valid = cnt != '0;
  assign wr_space = cnt != (QueuePtrW+1)'(QueueDepth);
  assign do_wr = wr_valid && wr_space;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + 1'b1;
      if (do_rd) rp <= rp + 1'b1;
      cnt <= cnt + (QueuePtrW+1)'(do_wr) - (QueuePtrW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) !(do_rd && cnt == '0))
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !wr_space) |=> cnt == (QueuePtrW+1)'(QueueDepth) || $past(do_rd))
    else $error("queue dropped write");

endmodule

>>> hw/rtl/bpc_back.sv
// Back part: pipelined 32-step divider and second-order correction.
module bpc_back import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  bpc_job_t    job,
  input  logic        advance,
  input  logic [63:0] press_coeffs_b,
  input  logic [15:0] press_coeff_p9,
  output logic        res_valid,
  output logic [31:0] res_pressure,
  output logic        res_zero,
  output logic        res_invalid
);

  // divider: one quotient bit per stage
  logic [DivSteps:0] dv;
  logic [31:0] rem [0:DivSteps];
  logic [31:0] quo [0:DivSteps];
  logic [31:0] num [0:DivSteps];
  logic [31:0] den [0:DivSteps];
  logic [DivSteps:0] dbl, zf, inv;

  assign dv[0] = in_valid;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign num[0] = job.dividend;
  assign den[0] = job.divisor;
  assign dbl[0] = job.post_double;
  assign zf[0] = job.zero_div;
  assign inv[0] = job.invalid;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [32:0] r_sh;
    logic [32:0] r_sub;
    assign r_sh = {rem[k], num[k][31]};
    assign r_sub = r_sh - {1'b0, den[k]};
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (advance) dv[k+1] <= dv[k];
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        num[k+1] <= num[k] << 1;
        den[k+1] <= den[k];
        dbl[k+1] <= dbl[k];
        zf[k+1] <= zf[k];
        inv[k+1] <= inv[k];
        if (!r_sub[32]) begin
          rem[k+1] <= r_sub[31:0];
          quo[k+1] <= {quo[k][30:0], 1'b1};
        end else begin
          rem[k+1] <= r_sh[31:0];
          quo[k+1] <= {quo[k][30:0], 1'b0};
        end
      end
    end
  end

  logic [31:0] p7, p8, p9, pq, p3s;
  logic c0_v, c1_v, c2_v, c0_z, c1_z, c2_z, c0_i, c1_i, c2_i;
  logic [31:0] c0_p, c1_p, c1_sq, c1_b, c2_a, c2_b, c2_p;

  assign p7 = sx16(press_coeffs_b[47:32]);
  assign p8 = sx16(press_coeffs_b[63:48]);
  assign p9 = sx16(press_coeff_p9);
  assign pq = dbl[DivSteps] ? (quo[DivSteps] << 1) : quo[DivSteps];
  assign p3s = c0_p >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_v <= 1'b0;
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      c0_v <= dv[DivSteps];
      c1_v <= c0_v;
      c2_v <= c1_v;
      res_valid <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c0_p <= pq;
      c0_z <= zf[DivSteps];
      c0_i <= inv[DivSteps];
      c1_p <= c0_p;
      c1_sq <= (p3s * p3s) >> 13;
      c1_b <= asr((c0_p >> 2) * p8, 5'd13);
      c1_z <= c0_z;
      c1_i <= c0_i;
      c2_p <= c1_p;
      c2_a <= asr(p9 * c1_sq, 5'd12);
      c2_b <= c1_b;
      c2_z <= c1_z;
      c2_i <= c1_i;
      res_zero <= c2_z;
      res_invalid <= c2_i;
      res_pressure <= (c2_z || c2_i) ? 32'd0 : c2_p + asr(c2_a + c2_b + p7, 5'd4);
    end
  end

endmodule

>>> hw/rtl/barometric_pressure_compensation.sv
// Pipeline: 7 front stages, a queue, 32 divider stages, 4 correction stages.
// Throughput: one beat per cycle when not stalled; the 32-stage restoring divider sets latency.
// Output register and front queue let input accept while a result waits.
// Back part stalls as a whole when the output is not taken; the front stalls
// only when the 4-entry queue is full. Reset (rst, synchronous) clears all
// valid bits, queue pointers and coefficient registers to zero.
module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [19:0]   raw_temperature,
  input  logic [19:0]   raw_pressure,
  input  logic          bus_error,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   pressure_pa,
  output logic          zero_divisor,
  output logic          invalid
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a, press_coeffs_b;
  logic [15:0] press_coeff_p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeff_p9 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTemp:   temp_coeffs <= cfg_data[47:0];
        RegPressA: press_coeffs_a <= cfg_data;
        RegPressB: press_coeffs_b <= cfg_data;
        RegP9:     press_coeff_p9 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front advances whenever the queue can take its last stage
  logic front_adv, fj_valid, q_space, q_valid, back_adv;
  bpc_job_t fj, qj;

  assign front_adv = q_space || !fj_valid;
  assign in_ready = front_adv;

  bpc_front u_front (
    .clk, .rst,
    .in_valid(in_valid && in_ready),
    .raw_temperature, .raw_pressure, .bus_error,
    .advance(front_adv),
    .temp_coeffs, .press_coeffs_a, .press_coeffs_b,
    .job_valid(fj_valid), .job(fj)
  );

  // only push on front advance so a beat is written once
  bpc_queue u_queue (
    .clk, .rst,
    .wr_valid(fj_valid && front_adv), .wr_data(fj), .wr_space(q_space),
    .rd_valid(q_valid), .rd_ready(back_adv), .rd_data(qj)
  );

  assign back_adv = out_ready || !out_valid;

  bpc_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .job(qj), .advance(back_adv),
    .press_coeffs_b, .press_coeff_p9,
    .res_valid(out_valid), .res_pressure(pressure_pa),
    .res_zero(zero_divisor), .res_invalid(invalid)
  );

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(zero_divisor && invalid))
    else $error("both error flags set");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (zero_divisor || invalid)) |-> pressure_pa == 32'd0)
    else $error("error result not zero");

endmodule
